/* rtl/core/wvad_pkg.sv */
// ----------------------------------------------------------------------------
// Windowed variation anomaly detector package
// Register indexes, reset values, signal classes and datapath widths.
// ----------------------------------------------------------------------------
package wvad_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int WLEN_W = 7;
	localparam int PROD_W = 64;
	localparam int ACC_W = 128;
	localparam int HALF_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_VOLTAGE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR_CURRENT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THR_FREQUENCY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THR_OTHER = 3'd4;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd60;
	localparam logic [CFG_DATA_W-1:0] THR_VOLTAGE_RESET = 32'd1678;
	localparam logic [CFG_DATA_W-1:0] THR_CURRENT_RESET = 32'd2516582;
	localparam logic [CFG_DATA_W-1:0] THR_FREQUENCY_RESET = 32'd16777;
	localparam logic [CFG_DATA_W-1:0] THR_OTHER_RESET = 32'd16777216;

	localparam logic [1:0] CLASS_VOLTAGE = 2'd0;
	localparam logic [1:0] CLASS_CURRENT = 2'd1;
	localparam logic [1:0] CLASS_FREQUENCY = 2'd2;
	localparam logic [1:0] CLASS_OTHER = 2'd3;

	typedef logic [PROD_W-1:0] word_t;
	typedef logic [ACC_W-1:0] wide_t;

endpackage

/* rtl/core/windowed_variation_anomaly_detector.sv */
// ----------------------------------------------------------------------------
// Windowed variation anomaly detector
// Cuts each signal into fixed windows, keeps sum and sum of squares, and
// flags a window whose spread against its mean exceeds the class threshold.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                 Payload
//  in       in_valid / in_stall       sample, signal_class, timestamp,
//                                     last_in_signal
//  out      out_valid / out_stall     anomaly, window_time, window_start,
//                                     window_count, window_sum
//  cfg      cfg_wr_en                 cfg_index, cfg_wdata
//
//  in_stall is high from acceptance until the item is done, so the next item
//  is taken only once the block is back in ST_IDLE. An item that closes a
//  window with a result due also runs PH_S1SQ, PH_KS2, PH_KD, PH_TSQ and
//  PH_R, and waits in ST_EMIT while out_stall holds the previous result.
//  One 32x32 multiplier makes all products, four partials per 64-bit product.
//  Reset clears all window and signal state and loads the default registers.
//
module windowed_variation_anomaly_detector
	import wvad_pkg::*;
#(
	parameter int MAX_WINDOW = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_BITS-1:0]  sample,
	input  logic [1:0]                     signal_class,
	input  logic [63:0]                    timestamp,
	input  logic                           last_in_signal,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           anomaly,
	output logic [63:0]                    window_time,
	output logic [31:0]                    window_start,
	output logic [6:0]                     window_count,
	output logic signed [29:0]             window_sum,
	input  logic                           cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_wdata
);

	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int LW = ((CW > WLEN_W) ? CW : WLEN_W) + 1;
	localparam int SW = SAMPLE_BITS + CW;
	localparam int S2W = 2 * SAMPLE_BITS - 2 + CW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_POST = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	localparam logic [2:0] PH_SQ = 3'd0;
	localparam logic [2:0] PH_S1SQ = 3'd1;
	localparam logic [2:0] PH_KS2 = 3'd2;
	localparam logic [2:0] PH_KD = 3'd3;
	localparam logic [2:0] PH_TSQ = 3'd4;
	localparam logic [2:0] PH_R = 3'd5;

	logic [2:0] state_q;
	logic [2:0] phase_q;
	logic [1:0] step_q;

	logic [WLEN_W-1:0] wlen_q;
	logic [CFG_DATA_W-1:0] thr_v_q, thr_c_q, thr_f_q, thr_o_q;

	logic signed [SW-1:0] sum_q;
	logic [S2W-1:0] s2_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] pos_q;
	logic [31:0] start_pos_q;
	logic [63:0] start_time_q;
	logic det_q;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [1:0] cls_q;
	logic last_q;
	logic close_q;
	logic anom_q;
	word_t opa_q, opb_q;
	wide_t acc_q;
	word_t s1sq_q, dev_q, kd_q;

	logic out_valid_q;
	logic anomaly_q;
	logic [63:0] wtime_q;
	logic [31:0] wstart_q;
	logic [6:0] wcount_q;
	logic [29:0] wsum_q;

	logic [SAMPLE_BITS-1:0] smag;
	logic [HALF_W-1:0] a_part, b_part;
	word_t pp;
	wide_t pp_shift;
	logic [LW-1:0] len, cnt_next;
	logic close_now;
	word_t sum64, s1mag, k64, s2_64, acc_lo, dev_next;
	logic [CFG_DATA_W-1:0] thr_sel;
	wide_t lhs;
	logic judge;
	logic [LW-1:0] cnt_wide;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign anomaly = anomaly_q;
	assign window_time = wtime_q;
	assign window_start = wstart_q;
	assign window_count = wcount_q;
	assign window_sum = wsum_q;

	always_comb begin
		smag = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample + 1'b1) : SAMPLE_BITS'(sample);
		a_part = step_q[1] ? opa_q[2*HALF_W-1:HALF_W] : opa_q[HALF_W-1:0];
		b_part = step_q[0] ? opb_q[2*HALF_W-1:HALF_W] : opb_q[HALF_W-1:0];
		pp = PROD_W'(a_part) * PROD_W'(b_part);
		case (step_q)
			2'd0: pp_shift = ACC_W'(pp);
			2'd3: pp_shift = ACC_W'(pp) << (2 * HALF_W);
			default: pp_shift = ACC_W'(pp) << HALF_W;
		endcase

		if (wlen_q == '0) begin
			len = LW'(1);
		end else if (LW'(wlen_q) > LW'(MAX_WINDOW)) begin
			len = LW'(MAX_WINDOW);
		end else begin
			len = LW'(wlen_q);
		end
		cnt_next = LW'(cnt_q) + LW'(1);
		close_now = (cnt_next >= len) || last_q;

		sum64 = {{(PROD_W-SW){sum_q[SW-1]}}, sum_q};
		s1mag = sum_q[SW-1] ? (PROD_W'(0) - sum64) : sum64;
		k64 = PROD_W'(cnt_q);
		s2_64 = PROD_W'(s2_q);
		acc_lo = acc_q[PROD_W-1:0];
		dev_next = (acc_lo >= s1sq_q) ? (acc_lo - s1sq_q) : PROD_W'(0);

		case (cls_q)
			CLASS_VOLTAGE: thr_sel = thr_v_q;
			CLASS_CURRENT: thr_sel = thr_c_q;
			CLASS_FREQUENCY: thr_sel = thr_f_q;
			default: thr_sel = thr_o_q;
		endcase

		lhs = {16'd0, kd_q, 48'd0};
		if (sum_q == '0) begin
			judge = (dev_q != '0);
		end else if (sum_q[SW-1]) begin
			judge = 1'b0;
		end else begin
			judge = (lhs > acc_q);
		end
		cnt_wide = LW'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
			thr_v_q <= THR_VOLTAGE_RESET;
			thr_c_q <= THR_CURRENT_RESET;
			thr_f_q <= THR_FREQUENCY_RESET;
			thr_o_q <= THR_OTHER_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: wlen_q <= cfg_wdata[WLEN_W-1:0];
				REG_THR_VOLTAGE: thr_v_q <= cfg_wdata;
				REG_THR_CURRENT: thr_c_q <= cfg_wdata;
				REG_THR_FREQUENCY: thr_f_q <= cfg_wdata;
				REG_THR_OTHER: thr_o_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_SQ;
			step_q <= 2'd0;
			close_q <= 1'b0;
			out_valid_q <= 1'b0;
			sum_q <= '0;
			s2_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
			start_pos_q <= '0;
			start_time_q <= '0;
			det_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (cnt_q == '0) begin
							start_time_q <= timestamp;
							start_pos_q <= pos_q;
						end
						phase_q <= PH_SQ;
						step_q <= 2'd0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					step_q <= 2'd0;
					unique case (phase_q)
						PH_SQ: begin
							sum_q <= sum_q + SW'(x_q);
							s2_q <= s2_q + acc_q[S2W-1:0];
							cnt_q <= cnt_next[CW-1:0];
							if (pos_q != '1) begin
								pos_q <= pos_q + 32'd1;
							end
							close_q <= close_now;
							state_q <= ST_DECIDE;
						end
						PH_S1SQ: begin
							phase_q <= PH_KS2;
							state_q <= ST_MUL;
						end
						PH_KS2: begin
							phase_q <= PH_KD;
							state_q <= ST_MUL;
						end
						PH_KD: begin
							phase_q <= PH_TSQ;
							state_q <= ST_MUL;
						end
						PH_TSQ: begin
							phase_q <= PH_R;
							state_q <= ST_MUL;
						end
						PH_R: begin
							state_q <= ST_EMIT;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_DECIDE: begin
					step_q <= 2'd0;
					if (close_q && !det_q) begin
						phase_q <= PH_S1SQ;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						det_q <= det_q | anom_q;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (close_q || last_q) begin
						sum_q <= '0;
						s2_q <= '0;
						cnt_q <= '0;
					end
					if (last_q) begin
						pos_q <= '0;
						start_pos_q <= '0;
						start_time_q <= '0;
						det_q <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					x_q <= sample;
					cls_q <= signal_class;
					last_q <= last_in_signal;
					opa_q <= PROD_W'(smag);
					opb_q <= PROD_W'(smag);
					acc_q <= '0;
				end
			end
			ST_MUL: begin
				acc_q <= acc_q + pp_shift;
			end
			ST_POST: begin
				acc_q <= '0;
				unique case (phase_q)
					PH_S1SQ: begin
						s1sq_q <= acc_lo;
						opa_q <= k64;
						opb_q <= s2_64;
					end
					PH_KS2: begin
						dev_q <= dev_next;
						opa_q <= k64;
						opb_q <= dev_next;
					end
					PH_KD: begin
						kd_q <= acc_lo;
						opa_q <= PROD_W'(thr_sel);
						opb_q <= PROD_W'(thr_sel);
					end
					PH_TSQ: begin
						opa_q <= acc_lo;
						opb_q <= s1sq_q;
					end
					PH_R: begin
						anom_q <= judge;
					end
					default: begin
					end
				endcase
			end
			ST_DECIDE: begin
				acc_q <= '0;
				opa_q <= s1mag;
				opb_q <= s1mag;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					anomaly_q <= anom_q;
					wtime_q <= start_time_q;
					wstart_q <= start_pos_q;
					wcount_q <= cnt_wide[6:0];
					wsum_q <= sum64[29:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule
